/* sv/pbd_pkg.sv */
// ----------------------------------------------------------------------------
// pbd_pkg: shared types and constants of the point-box distance query
// Widths of the coordinate, difference, square and root paths, the register
// indexes of the configuration port and the records passed between parts.
// ----------------------------------------------------------------------------
package pbd_pkg;

    // Coordinate and arithmetic widths.
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = 17;
    localparam int GAP_W     = 16;
    localparam int SQ_W      = 33;
    localparam int ROOT_W    = 17;
    localparam int REM_W     = 35;
    localparam int SDIST_W   = 18;
    localparam int CFG_IDX_W = 2;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 2'd3;

    // Reset values of the box bounds.
    localparam logic signed [COORD_W-1:0] BOX_MIN_RESET = 16'sh8000;
    localparam logic signed [COORD_W-1:0] BOX_MAX_RESET = 16'sh7fff;

    // Box bounds as held in configuration.
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
    } box_t;

    // Classified query handed from the front to the back.
    typedef struct packed {
        logic                      is_inside;
        logic signed [COORD_W-1:0] closest_x;
        logic signed [COORD_W-1:0] closest_y;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [GAP_W-1:0]          gap_x;
        logic [GAP_W-1:0]          gap_y;
    } query_t;

endpackage

/* sv/point_box_distance_query.sv */
// ----------------------------------------------------------------------------
// point_box_distance_query: 2D point to axis-aligned box distance
// Tests each point against the configured box and returns containment, the
// closest box point, the squared distance and a signed distance.
//
//   Channel   Direction  Handshake                   Payload
//   config    in         cfg_we                      cfg_index, cfg_wdata
//   point     in         point_valid / point_ready   point_x, point_y
//   result    out        result_valid / result_ready is_inside, closest_x,
//                                                    closest_y, dist_squared,
//                                                    signed_dist
//
// One point is taken per cycle while nothing stalls; a result passes the front
// register, the queue, the square and sum stages, the 17-stage square root pipeline
// and the result register. Reset clears all valid flags and queue pointers and
// loads the widest box. A stalled result freezes the back pipeline; the queue lets
// the front keep taking points until it fills.
// ----------------------------------------------------------------------------
module point_box_distance_query #(
    parameter int QUEUE_DEPTH = pbd_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pbd_pkg::COORD_W-1:0]         cfg_wdata,
    input  logic                                point_valid,
    output logic                                point_ready,
    input  logic signed [pbd_pkg::COORD_W-1:0]  point_x,
    input  logic signed [pbd_pkg::COORD_W-1:0]  point_y,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                is_inside,
    output logic signed [pbd_pkg::COORD_W-1:0]  closest_x,
    output logic signed [pbd_pkg::COORD_W-1:0]  closest_y,
    output logic [pbd_pkg::SQ_W-1:0]            dist_squared,
    output logic signed [pbd_pkg::SDIST_W-1:0]  signed_dist
);

    pbd_pkg::box_t   box_reg;
    logic            fq_valid;
    logic            fq_ready;
    pbd_pkg::query_t fq_data;
    logic            qb_valid;
    logic            qb_ready;
    pbd_pkg::query_t qb_data;

    // Box registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.min_x <= pbd_pkg::BOX_MIN_RESET;
            box_reg.min_y <= pbd_pkg::BOX_MIN_RESET;
            box_reg.max_x <= pbd_pkg::BOX_MAX_RESET;
            box_reg.max_y <= pbd_pkg::BOX_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbd_pkg::REG_BOX_MIN_X: box_reg.min_x <= $signed(cfg_wdata);
                pbd_pkg::REG_BOX_MIN_Y: box_reg.min_y <= $signed(cfg_wdata);
                pbd_pkg::REG_BOX_MAX_X: box_reg.max_x <= $signed(cfg_wdata);
                pbd_pkg::REG_BOX_MAX_Y: box_reg.max_y <= $signed(cfg_wdata);
            endcase
        end
    end

    // Front: classification of incoming points.
    pbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .box         (box_reg),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    // Queue between front and back.
    pbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // Back: distance evaluation.
    pbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (qb_valid),
        .in_ready     (qb_ready),
        .in_data      (qb_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_inside    (is_inside),
        .closest_x    (closest_x),
        .closest_y    (closest_y),
        .dist_squared (dist_squared),
        .signed_dist  (signed_dist)
    );

endmodule

/* sv/pbd_front.sv */
// ----------------------------------------------------------------------------
// pbd_front: query classification
// Accepts a point, tests it against the box, clamps it, forms the offsets to
// the closest box point and the smaller edge gap on each axis.
// ----------------------------------------------------------------------------
module pbd_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pbd_pkg::box_t                      box,
    input  logic                               point_valid,
    output logic                               point_ready,
    input  logic signed [pbd_pkg::COORD_W-1:0] point_x,
    input  logic signed [pbd_pkg::COORD_W-1:0] point_y,
    output logic                               q_valid,
    input  logic                               q_ready,
    output pbd_pkg::query_t                    q_data
);

    logic                               below_x;
    logic                               above_x;
    logic                               below_y;
    logic                               above_y;
    logic signed [pbd_pkg::COORD_W-1:0] raise_x;
    logic signed [pbd_pkg::COORD_W-1:0] raise_y;
    logic signed [pbd_pkg::COORD_W-1:0] clamp_x;
    logic signed [pbd_pkg::COORD_W-1:0] clamp_y;
    logic [pbd_pkg::GAP_W-1:0]          lo_gap_x;
    logic [pbd_pkg::GAP_W-1:0]          hi_gap_x;
    logic [pbd_pkg::GAP_W-1:0]          lo_gap_y;
    logic [pbd_pkg::GAP_W-1:0]          hi_gap_y;
    pbd_pkg::query_t                    query;
    logic                               accept;
    logic                               front_valid_reg;
    logic                               front_valid_next;
    pbd_pkg::query_t                    front_data_reg;

    // Bound tests and clamp: raise to min first, then lower to max.
    always_comb
    begin
        below_x = point_x < box.min_x;
        above_x = point_x > box.max_x;
        below_y = point_y < box.min_y;
        above_y = point_y > box.max_y;
        raise_x = below_x ? box.min_x : point_x;
        raise_y = below_y ? box.min_y : point_y;
        clamp_x = (raise_x > box.max_x) ? box.max_x : raise_x;
        clamp_y = (raise_y > box.max_y) ? box.max_y : raise_y;
    end

    // Offsets to the closest point and edge gaps. The gaps only matter for a
    // point inside the box, where each of them fits in sixteen unsigned bits.
    always_comb
    begin
        lo_gap_x = point_x - box.min_x;
        hi_gap_x = box.max_x - point_x;
        lo_gap_y = point_y - box.min_y;
        hi_gap_y = box.max_y - point_y;

        query.is_inside = !below_x && !above_x && !below_y && !above_y;
        query.closest_x = clamp_x;
        query.closest_y = clamp_y;
        query.dx = $signed({clamp_x[pbd_pkg::COORD_W-1], clamp_x}
                 - {point_x[pbd_pkg::COORD_W-1], point_x});
        query.dy = $signed({clamp_y[pbd_pkg::COORD_W-1], clamp_y}
                 - {point_y[pbd_pkg::COORD_W-1], point_y});
        query.gap_x = (lo_gap_x < hi_gap_x) ? lo_gap_x : hi_gap_x;
        query.gap_y = (lo_gap_y < hi_gap_y) ? lo_gap_y : hi_gap_y;
    end

    // Output stage: takes a new point whenever it is empty or being drained.
    assign point_ready = !front_valid_reg || q_ready;
    assign accept      = point_valid && point_ready;

    always_comb
    begin
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_data_reg <= query;
        end
    end

    assign q_valid = front_valid_reg;
    assign q_data  = front_data_reg;

endmodule

/* sv/pbd_queue.sv */
// ----------------------------------------------------------------------------
// pbd_queue: classified query queue
// A short first-in first-out queue that lets the front and the back stall
// independently of each other.
// ----------------------------------------------------------------------------
module pbd_queue #(
    parameter int DEPTH = pbd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  pbd_pkg::query_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output pbd_pkg::query_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    pbd_pkg::query_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    // Handshakes on both sides.
    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/pbd_back.sv */
// ----------------------------------------------------------------------------
// pbd_back: distance evaluation pipeline
// Squares the offsets, sums them, takes the truncated square root one bit per
// stage and selects the signed distance into the result register.
// ----------------------------------------------------------------------------
module pbd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pbd_pkg::query_t                     in_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                is_inside,
    output logic signed [pbd_pkg::COORD_W-1:0]  closest_x,
    output logic signed [pbd_pkg::COORD_W-1:0]  closest_y,
    output logic [pbd_pkg::SQ_W-1:0]            dist_squared,
    output logic signed [pbd_pkg::SDIST_W-1:0]  signed_dist
);

    localparam int NSTG = pbd_pkg::ROOT_W;

    logic                                adv;
    logic [pbd_pkg::SQ_W-1:0]            dx_prod;
    logic [pbd_pkg::SQ_W-1:0]            dy_prod;

    // Square stage.
    logic                                sq_valid_reg;
    logic                                sq_inside_reg;
    logic signed [pbd_pkg::COORD_W-1:0]  sq_cx_reg;
    logic signed [pbd_pkg::COORD_W-1:0]  sq_cy_reg;
    logic [pbd_pkg::GAP_W-1:0]           sq_gap_reg;
    logic [pbd_pkg::SQ_W-1:0]            sq_dx2_reg;
    logic [pbd_pkg::SQ_W-1:0]            sq_dy2_reg;

    // Root stages: entry 0 holds the sum, entry k the state after k bits.
    logic [NSTG:0]                       rs_valid_reg;
    logic                                rs_inside_reg [NSTG+1];
    logic signed [pbd_pkg::COORD_W-1:0]  rs_cx_reg     [NSTG+1];
    logic signed [pbd_pkg::COORD_W-1:0]  rs_cy_reg     [NSTG+1];
    logic [pbd_pkg::GAP_W-1:0]           rs_gap_reg    [NSTG+1];
    logic [pbd_pkg::SQ_W-1:0]            rs_d2_reg     [NSTG+1];
    logic [pbd_pkg::REM_W-1:0]           rs_rem_reg    [NSTG+1];
    logic [pbd_pkg::ROOT_W-1:0]          rs_root_reg   [NSTG+1];

    // Result register.
    logic                                out_valid_reg;
    logic                                out_inside_reg;
    logic signed [pbd_pkg::COORD_W-1:0]  out_cx_reg;
    logic signed [pbd_pkg::COORD_W-1:0]  out_cy_reg;
    logic [pbd_pkg::SQ_W-1:0]            out_d2_reg;
    logic signed [pbd_pkg::SDIST_W-1:0]  out_sd_reg;
    logic signed [pbd_pkg::SDIST_W-1:0]  sd_sel;

    // The whole pipeline moves when the result register is free or drained.
    assign adv      = !out_valid_reg || result_ready;
    assign in_ready = adv;

    // Squares of the offsets; each magnitude stays below 2^16.
    assign dx_prod = in_data.dx * in_data.dx;
    assign dy_prod = in_data.dy * in_data.dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_inside_reg <= in_data.is_inside;
            sq_cx_reg     <= in_data.closest_x;
            sq_cy_reg     <= in_data.closest_y;
            sq_gap_reg    <= (in_data.gap_x < in_data.gap_y) ? in_data.gap_x
                                                              : in_data.gap_y;
            sq_dx2_reg    <= dx_prod;
            sq_dy2_reg    <= dy_prod;
        end
    end

    // Sum stage, which also seeds the root recurrence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            rs_valid_reg[0] <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_inside_reg[0] <= sq_inside_reg;
            rs_cx_reg[0]     <= sq_cx_reg;
            rs_cy_reg[0]     <= sq_cy_reg;
            rs_gap_reg[0]    <= sq_gap_reg;
            rs_d2_reg[0]     <= sq_dx2_reg + sq_dy2_reg;
            rs_rem_reg[0]    <= pbd_pkg::REM_W'(sq_dx2_reg + sq_dy2_reg);
            rs_root_reg[0]   <= '0;
        end
    end

    // One root bit per stage, most significant first: the bit is set when the
    // remainder covers 2*root*2^i + 2^(2i).
    for (genvar k = 0; k < NSTG; k++)
    begin : g_root
        localparam int BIT = NSTG - 1 - k;

        logic [pbd_pkg::REM_W-1:0]  trial;
        logic                       take;
        logic [pbd_pkg::REM_W-1:0]  rem_new;
        logic [pbd_pkg::ROOT_W-1:0] root_new;

        always_comb
        begin
            trial    = (pbd_pkg::REM_W'(rs_root_reg[k]) << (BIT + 1))
                     | (pbd_pkg::REM_W'(1) << (2 * BIT));
            take     = rs_rem_reg[k] >= trial;
            rem_new  = take ? rs_rem_reg[k] - trial : rs_rem_reg[k];
            root_new = take ? rs_root_reg[k] | (pbd_pkg::ROOT_W'(1) << BIT)
                            : rs_root_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rs_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                rs_valid_reg[k+1] <= rs_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rs_inside_reg[k+1] <= rs_inside_reg[k];
                rs_cx_reg[k+1]     <= rs_cx_reg[k];
                rs_cy_reg[k+1]     <= rs_cy_reg[k];
                rs_gap_reg[k+1]    <= rs_gap_reg[k];
                rs_d2_reg[k+1]     <= rs_d2_reg[k];
                rs_rem_reg[k+1]    <= rem_new;
                rs_root_reg[k+1]   <= root_new;
            end
        end
    end

    // Inside: minus the nearest edge gap. Outside: the truncated root.
    always_comb
    begin
        if (rs_inside_reg[NSTG])
        begin
            sd_sel = -$signed({2'b00, rs_gap_reg[NSTG]});
        end
        else
        begin
            sd_sel = $signed({1'b0, rs_root_reg[NSTG]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= rs_valid_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_inside_reg <= rs_inside_reg[NSTG];
            out_cx_reg     <= rs_cx_reg[NSTG];
            out_cy_reg     <= rs_cy_reg[NSTG];
            out_d2_reg     <= rs_d2_reg[NSTG];
            out_sd_reg     <= sd_sel;
        end
    end

    assign result_valid = out_valid_reg;
    assign is_inside    = out_inside_reg;
    assign closest_x    = out_cx_reg;
    assign closest_y    = out_cy_reg;
    assign dist_squared = out_d2_reg;
    assign signed_dist  = out_sd_reg;

    // A transfer from the queue always lands in the square stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> sq_valid_reg)
        else $error("accepted query missing from square stage");

    // A stalled result freezes the pipeline: the square and root stage valid flags hold.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> ($stable(rs_valid_reg) && $stable(sq_valid_reg)))
        else $error("pipeline moved while result stalled");

    // A point inside the box is its own closest point.
    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_inside) |-> (dist_squared == '0))
        else $error("inside point with nonzero squared distance");

    // The sign of the distance follows containment.
    a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((!is_inside || signed_dist[pbd_pkg::SDIST_W-1]
                           || (signed_dist == '0))
                          && (is_inside || !signed_dist[pbd_pkg::SDIST_W-1])))
        else $error("signed distance sign disagrees with containment");

endmodule
